### design/priority_wait_counting_semaphore_macros.svh
// Assertion macros for the priority wait semaphore.
// Included by the datapath and the top level; no other dependencies.
`ifndef PRIORITY_WAIT_COUNTING_SEMAPHORE_MACROS_SVH
`define PRIORITY_WAIT_COUNTING_SEMAPHORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PWS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PWS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PWS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PWS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### design/pws_pkg.sv
// Package for the priority wait semaphore: widths, codes, command struct.
// No dependencies.
`default_nettype none
package pws_pkg;
  localparam int MaxWaiters = 16;
  localparam int TotW = $clog2(MaxWaiters + 1);
  localparam int TidBits = 8;
  localparam int CntW = 16;

  localparam logic [2:0] FN_WAIT = 3'd0;
  localparam logic [2:0] FN_SIGNAL = 3'd1;
  localparam logic [2:0] FN_TRY = 3'd2;
  localparam logic [2:0] FN_PRIO = 3'd3;
  localparam logic [2:0] FN_CANCEL = 3'd4;

  localparam logic [2:0] ST_GRANTED = 3'd0;
  localparam logic [2:0] ST_BLOCKED = 3'd1;
  localparam logic [2:0] ST_REFUSED = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request, do first step
    logic step2;    // second step (reinsert / release head)
    logic init;     // config write
  } pws_cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic wake_valid;
    logic [7:0] wake_thread;
    logic held;
    logic [15:0] count_now;
    logic saturated;
  } pws_res_t;
endpackage
`default_nettype wire

### design/pws_chan_if.sv
// Valid/ready channel interfaces for request, result and config beats.
// No dependencies.
`default_nettype none
interface pws_req_if;
  logic valid;
  logic ready;
  logic [2:0] func;
  logic [7:0] thread_id;
  logic [7:0] priority_req;
  modport source (output valid, func, thread_id, priority_req, input ready);
  modport sink (input valid, func, thread_id, priority_req, output ready);
endinterface

interface pws_rsp_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic wake_valid;
  logic [7:0] wake_thread;
  logic held;
  logic [15:0] count_now;
  logic saturated;
  modport source (output valid, status, wake_valid, wake_thread, held, count_now, saturated,
                  input ready);
  modport sink (input valid, status, wake_valid, wake_thread, held, count_now, saturated,
                output ready);
endinterface

interface pws_cfg_if;
  logic valid;
  logic ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### design/pws_datapath.sv
// Datapath: count register and a sorted row of waiter cells with shift insert/remove.
// Depends on pws_pkg and the macros header.
`default_nettype none
`include "priority_wait_counting_semaphore_macros.svh"
module pws_datapath
  import pws_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire pws_cmd_t cmd_i,
  input  wire logic [2:0] func_i,
  input  wire logic [7:0] tid_i,
  input  wire logic [7:0] pri_i,
  input  wire logic [15:0] init_i,
  output pws_res_t res_o
);
  logic [7:0] thr_q [MaxWaiters];
  logic [7:0] pri_q [MaxWaiters];
  logic [7:0] thr_d [MaxWaiters];
  logic [7:0] pri_d [MaxWaiters];
  logic [TotW-1:0] tot_q, tot_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [2:0] fn_q, fn_d;
  logic [7:0] tid_q, tid_d, rpri_q, rpri_d;
  pws_res_t res_q, res_d;

  logic [MaxWaiters-1:0] occ, ge, hit, hit_first, rm_mask, ins_before;
  logic found;

  // per-cell compares against the captured (or incoming) request
  logic [7:0] ctid, cpri;
  always_comb begin
    ctid = cmd_i.load ? (tid_i & 8'((1 << TidBits) - 1)) : tid_q;
    cpri = cmd_i.load ? pri_i : rpri_q;
    for (int k = 0; k < MaxWaiters; k++) begin
      occ[k] = (TotW'(k) < tot_q);
      ge[k] = occ[k] && (pri_q[k] >= cpri);
      hit[k] = occ[k] && (thr_q[k] == ctid);
    end
    hit_first = hit & (~hit + 1'b1);
    found = |hit;
    // cells at or after the first hit
    rm_mask = '0;
    rm_mask[0] = hit_first[0];
    for (int k = 1; k < MaxWaiters; k++) begin
      rm_mask[k] = rm_mask[k-1] | hit_first[k];
    end
    ins_before = ge;
  end

  always_comb begin
    thr_d = thr_q;
    pri_d = pri_q;
    tot_d = tot_q;
    cnt_d = cnt_q;
    fn_d = fn_q;
    tid_d = tid_q;
    rpri_d = rpri_q;
    res_d = res_q;
    if (cmd_i.init) begin
      cnt_d = init_i;
      tot_d = '0;
    end else if (cmd_i.load) begin
      fn_d = func_i;
      tid_d = ctid;
      rpri_d = pri_i;
      res_d = '0;
      res_d.status = ST_REFUSED;
      case (func_i)
        FN_WAIT, FN_TRY: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - 1'b1;
            res_d.status = ST_GRANTED;
          end else if (func_i == FN_TRY) begin
            res_d.status = ST_REFUSED;
          end else if (tot_q >= TotW'(MaxWaiters)) begin
            res_d.status = ST_FULL;
          end else begin
            // insert behind every entry of equal or higher priority
            for (int k = 0; k < MaxWaiters; k++) begin
              if (!ins_before[k]) begin
                if (k == 0 || ins_before[k-1]) begin
                  thr_d[k] = ctid;
                  pri_d[k] = cpri;
                end else begin
                  thr_d[k] = thr_q[k-1];
                  pri_d[k] = pri_q[k-1];
                end
              end
            end
            tot_d = tot_q + 1'b1;
            res_d.status = ST_BLOCKED;
          end
        end
        FN_SIGNAL: begin
          if (cnt_q == '1) res_d.saturated = 1'b1;
          else cnt_d = cnt_q + 1'b1;
          if (tot_q != '0) begin
            res_d.wake_valid = 1'b1;
            res_d.wake_thread = thr_q[0];
            for (int k = 0; k < MaxWaiters - 1; k++) begin
              thr_d[k] = thr_q[k+1];
              pri_d[k] = pri_q[k+1];
            end
            tot_d = tot_q - 1'b1;
          end
          res_d.status = ST_DONE;
        end
        FN_PRIO, FN_CANCEL: begin
          if (!found) begin
            res_d.status = ST_NOTFOUND;
          end else begin
            for (int k = 0; k < MaxWaiters - 1; k++) begin
              if (rm_mask[k]) begin
                thr_d[k] = thr_q[k+1];
                pri_d[k] = pri_q[k+1];
              end
            end
            tot_d = tot_q - 1'b1;
            res_d.status = ST_DONE;
          end
        end
        default: res_d.status = ST_REFUSED;
      endcase
    end else if (cmd_i.step2) begin
      // second step: reinsert for priority change, release head for cancel
      if (fn_q == FN_PRIO && res_q.status == ST_DONE) begin
        for (int k = 0; k < MaxWaiters; k++) begin
          if (!ins_before[k]) begin
            if (k == 0 || ins_before[k-1]) begin
              thr_d[k] = tid_q;
              pri_d[k] = rpri_q;
            end else begin
              thr_d[k] = thr_q[k-1];
              pri_d[k] = pri_q[k-1];
            end
          end
        end
        tot_d = tot_q + 1'b1;
      end else if (fn_q == FN_CANCEL && res_q.status == ST_DONE &&
                   cnt_q != '0 && tot_q != '0) begin
        res_d.wake_valid = 1'b1;
        res_d.wake_thread = thr_q[0];
        for (int k = 0; k < MaxWaiters - 1; k++) begin
          thr_d[k] = thr_q[k+1];
          pri_d[k] = pri_q[k+1];
        end
        tot_d = tot_q - 1'b1;
      end
    end
    res_d.count_now = cnt_d;
    res_d.held = (cnt_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= '0;
      cnt_q <= '0;
      fn_q <= FN_WAIT;
    end else begin
      tot_q <= tot_d;
      cnt_q <= cnt_d;
      fn_q <= fn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    thr_q <= thr_d;
    pri_q <= pri_d;
    tid_q <= tid_d;
    rpri_q <= rpri_d;
    res_q <= res_d;
  end

  assign res_o = res_q;

  `PWS_ASSERT_IMP(a_tot_range, clk_i, rst_ni, 1'b1, tot_q <= TotW'(MaxWaiters))
  `PWS_ASSERT_NXT(a_init_empty, clk_i, rst_ni, cmd_i.init, tot_q == '0)
  `PWS_ASSERT_IMP(a_wake_zero, clk_i, rst_ni, !res_q.wake_valid && !cmd_i.init &&
                  !cmd_i.load && !cmd_i.step2, res_q.wake_thread == '0 ||
                  res_q.wake_valid)
endmodule
`default_nettype wire

### design/pws_ctrl.sv
// Controller: sequences load, second step and result handoff.
// Depends on pws_pkg.
`default_nettype none
module pws_ctrl
  import pws_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic req_ready_o,
  output logic rsp_valid_o,
  input  wire logic rsp_ready_i,
  input  wire logic cfg_valid_i,
  output logic cfg_ready_o,
  output pws_cmd_t cmd_o
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STEP = 2'd1;
  localparam logic [1:0] S_OUT = 2'd2;
  logic [1:0] st_q, st_d;

  always_comb begin
    st_d = st_q;
    cmd_o = '0;
    req_ready_o = 1'b0;
    cfg_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    case (st_q)
      S_IDLE: begin
        cfg_ready_o = 1'b1;
        req_ready_o = !cfg_valid_i;
        if (cfg_valid_i) cmd_o.init = 1'b1;
        else if (req_valid_i) begin
          cmd_o.load = 1'b1;
          st_d = S_STEP;
        end
      end
      S_STEP: begin
        cmd_o.step2 = 1'b1;
        st_d = S_OUT;
      end
      S_OUT: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= S_IDLE;
    else st_q <= st_d;
  end
endmodule
`default_nettype wire

### design/priority_wait_counting_semaphore.sv
// Top level of the priority wait semaphore: controller plus datapath.
// Depends on pws_pkg, the channel interfaces and the macros header.
//
// Usage: requests arrive on req (func, thread_id, priority_req); one result
// beat per request leaves on rsp. The cfg channel loads initial_count,
// which sets the count and empties the waiter table; it is taken only
// while no request is in progress.
// Sequence: a request is taken in S_IDLE and worked in two steps (first
// update, then a second shift for reinsert or head release in S_STEP);
// its result is offered in S_OUT. One request is in progress at a time.
// Reset: count 0, table empty, no result pending.
// A stalled receiver holds the result; no new request is taken until the
// result beat completes.
`default_nettype none
`include "priority_wait_counting_semaphore_macros.svh"
module priority_wait_counting_semaphore
  import pws_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  pws_req_if.sink req,
  pws_rsp_if.source rsp,
  pws_cfg_if.sink cfg
);
  pws_cmd_t cmd;
  pws_res_t res;

  pws_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i(req.valid), .req_ready_o(req.ready),
    .rsp_valid_o(rsp.valid), .rsp_ready_i(rsp.ready),
    .cfg_valid_i(cfg.valid), .cfg_ready_o(cfg.ready),
    .cmd_o(cmd)
  );

  pws_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .func_i(req.func), .tid_i(req.thread_id), .pri_i(req.priority_req),
    .init_i(cfg.data), .res_o(res)
  );

  assign rsp.status = res.status;
  assign rsp.wake_valid = res.wake_valid;
  assign rsp.wake_thread = res.wake_thread;
  assign rsp.held = res.held;
  assign rsp.count_now = res.count_now;
  assign rsp.saturated = res.saturated;

  `PWS_ASSERT_NXT(a_one_inflight, clk_i, rst_ni, req.valid && req.ready, !req.ready)
  `PWS_ASSERT_IMP(a_held_cnt, clk_i, rst_ni, rsp.valid, rsp.held == (rsp.count_now == '0))
  `PWS_ASSERT_IMP(a_sat_max, clk_i, rst_ni, rsp.valid && rsp.saturated,
                  rsp.count_now == '1)
endmodule
`default_nettype wire
